>>> sv/rmfp_pkg.sv
`timescale 1ns / 1ps
// Package for the reader-module frame parser: framing constants, parser
// phases, status codes and the result record. No dependencies.
package rmfp_pkg;

	localparam logic [7:0] SOF_BYTE = 8'hBB;
	localparam logic [7:0] EOF_BYTE = 8'h7E;
	localparam logic [7:0] ERR_CMD = 8'hFF;
	localparam int FRAME_OVERHEAD = 7;
	localparam int DEF_FRAME_BUFFER_BYTES = 256;
	localparam logic [7:0] LIMIT_RESET = 8'd255;

	localparam int TDATA_W = 56;
	localparam int PADDR_W = 2;
	localparam logic [PADDR_W-1:0] ADDR_PAYLOAD_LIMIT = PADDR_W'(0);

	typedef enum logic [2:0] {
		PH_WAIT   = 3'd0,
		PH_SKIP   = 3'd1,
		PH_FIELDS = 3'd2,
		PH_DATA   = 3'd3,
		PH_CHECK  = 3'd4,
		PH_CLOSE  = 3'd5
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_HEADER   = 3'd1,
		ST_BAD_CHECKSUM = 3'd2,
		ST_BAD_END      = 3'd3,
		ST_MODULE_ERROR = 3'd4,
		ST_TOO_LONG     = 3'd5
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       out_kind;
		logic [7:0]  payload_byte;
		logic        is_last;
		logic [7:0]  frame_type;
		logic [7:0]  command_code;
		logic [15:0] payload_len;
		status_t     status;
		logic [7:0]  module_error_code;
	} res_t;

endpackage

>>> sv/reader_module_frame_parser.sv
`timescale 1ns / 1ps
// Reader-module frame parser, top level.
// Depends on rmfp_pkg, rmfp_regs, rmfp_parse and rmfp_outbuf.
//
// Usage: received serial bytes enter on the s_ stream, one byte per beat in
// s_tdata. Frames are 0xBB, type, command, 16-bit big-endian length,
// payload, additive checksum, 0x7E; the length field delimits the frame.
// Payload bytes with index below payload_limit (APB register at address
// 0, reset 255) and below FRAME_BUFFER_BYTES-7 leave on the m_ stream
// as they arrive with m_tuser low. The end byte gives one status beat
// with m_tuser and m_tlast high carrying type, command, length, status
// code and module error byte. Drop the streamed payload of a frame whose
// status is nonzero. Throughput: one byte per cycle while the output
// buffer has room. A byte is registered on accept; its result, if any,
// is pushed into the output register, or the skid entry if that is full.
// A stalled m_ side fills the output register and one skid entry; s_tready
// then drops until a beat leaves. Reset returns the parser to header search
// and empties both stages. Write payload_limit only while idle.
module reader_module_frame_parser #(
	parameter int FRAME_BUFFER_BYTES = rmfp_pkg::DEF_FRAME_BUFFER_BYTES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// [7:0] payload_byte, [15:8] frame_type, [23:16] command_code,
	// [39:24] payload_len, [42:40] status, [50:43] module_error_code, rest 0
	output logic [rmfp_pkg::TDATA_W-1:0] m_tdata,
	output logic                         m_tlast,  // is_last
	output logic                         m_tuser,  // [0] out_kind
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rmfp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import rmfp_pkg::*;

	logic [7:0] payload_limit;
	logic       room;
	logic       res_valid;
	res_t       res;
	res_t       out_res;

	rmfp_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.payload_limit (payload_limit)
	);

	rmfp_parse #(
		.FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
	) u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_byte       (s_tdata),
		.room          (room),
		.payload_limit (payload_limit),
		.res_valid     (res_valid),
		.res           (res)
	);

	rmfp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_res  (res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {5'h0, out_res.module_error_code, out_res.status,
		out_res.payload_len, out_res.command_code, out_res.frame_type,
		out_res.payload_byte};
	assign m_tlast = out_res.is_last;
	assign m_tuser = out_res.out_kind;

	a_kind_matches_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == m_tlast)
		else $error("result kind and last flag disagree");

	a_payload_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[TDATA_W-1:8] == '0)
		else $error("payload beat carries status fields");

	a_status_beat_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[7:0] == 8'h0 && m_tdata[42:40] <= 3'd5)
		else $error("status beat carries payload byte or bad status code");

endmodule

>>> sv/rmfp_regs.sv
`timescale 1ns / 1ps
// APB register block of the frame parser: holds payload_limit.
// Depends on rmfp_pkg.
module rmfp_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rmfp_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output logic [7:0]                   payload_limit
);
	import rmfp_pkg::*;

	logic [7:0] limit_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en && paddr == ADDR_PAYLOAD_LIMIT) begin
			limit_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_PAYLOAD_LIMIT) begin
			prdata = {24'h0, limit_q};
		end
	end

	assign payload_limit = limit_q;

endmodule

>>> sv/rmfp_parse.sv
`timescale 1ns / 1ps
// Frame parser core: input byte register, phase machine and frame state.
// Produces at most one result per byte. Depends on rmfp_pkg.
module rmfp_parse #(
	parameter int FRAME_BUFFER_BYTES = rmfp_pkg::DEF_FRAME_BUFFER_BYTES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              room,
	input  logic [7:0]        payload_limit,
	output logic              res_valid,
	output rmfp_pkg::res_t    res
);
	import rmfp_pkg::*;

	localparam logic [16:0] STORE_CAP = 17'(FRAME_BUFFER_BYTES - FRAME_OVERHEAD);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fire;

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;
	logic [15:0] left_q, left_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  first_q, first_d;
	logic        sum_bad_q, sum_bad_d;

	logic [15:0] len_full;
	logic [15:0] pos;
	logic        pass;
	logic        over;
	status_t     close_st;

	assign fire = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign len_full = len_q | {8'h0, byte_s1};
	assign pos = len_q - left_q;
	assign pass = ({8'h0, pos[7:0]} == pos && pos[7:0] < payload_limit) &&
		({1'b0, pos} < STORE_CAP);
	assign over = ({1'b0, len_q} > STORE_CAP) ||
		(payload_limit != 8'h0 && len_q > {8'h0, payload_limit});

	always_comb begin
		priority if (sum_bad_q) begin
			close_st = ST_BAD_CHECKSUM;
		end else if (byte_s1 != EOF_BYTE) begin
			close_st = ST_BAD_END;
		end else if (cmd_q == ERR_CMD) begin
			close_st = ST_MODULE_ERROR;
		end else if (over) begin
			close_st = ST_TOO_LONG;
		end else begin
			close_st = ST_OK;
		end
	end

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_WAIT: begin
				if (byte_s1 == SOF_BYTE) begin
					phase_d = PH_FIELDS;
				end else if (byte_s1 != EOF_BYTE) begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (byte_s1 == EOF_BYTE) begin
					phase_d = PH_WAIT;
				end
			end
			PH_FIELDS: begin
				if (left_q == 16'd1) begin
					phase_d = (len_full == 16'h0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA: begin
				if (left_q == 16'd1) begin
					phase_d = PH_CHECK;
				end
			end
			PH_CHECK: phase_d = PH_CLOSE;
			PH_CLOSE: phase_d = PH_WAIT;
			default: phase_d = PH_WAIT;
		endcase
	end

	// frame state and result
	always_comb begin
		type_d = type_q;
		cmd_d = cmd_q;
		len_d = len_q;
		left_d = left_q;
		sum_d = sum_q;
		first_d = first_q;
		sum_bad_d = sum_bad_q;
		res_valid = 1'b0;
		res = '0;
		unique case (phase_q)
			PH_WAIT: begin
				type_d = 8'h0;
				cmd_d = 8'h0;
				len_d = 16'h0;
				left_d = 16'h0;
				sum_d = 8'h0;
				first_d = 8'h0;
				sum_bad_d = 1'b0;
				if (byte_s1 == SOF_BYTE) begin
					left_d = 16'd4;
				end else if (byte_s1 == EOF_BYTE) begin
					res_valid = 1'b1;
					res.out_kind = KIND_STATUS;
					res.is_last = 1'b1;
					res.status = ST_BAD_HEADER;
				end
			end
			PH_SKIP: begin
				if (byte_s1 == EOF_BYTE) begin
					res_valid = 1'b1;
					res.out_kind = KIND_STATUS;
					res.is_last = 1'b1;
					res.status = ST_BAD_HEADER;
				end
			end
			PH_FIELDS: begin
				sum_d = sum_q + byte_s1;
				if (left_q == 16'd4) begin
					type_d = byte_s1;
					left_d = 16'd3;
				end else if (left_q == 16'd3) begin
					cmd_d = byte_s1;
					left_d = 16'd2;
				end else if (left_q == 16'd2) begin
					len_d = {byte_s1, 8'h0};
					left_d = 16'd1;
				end else begin
					len_d = len_full;
					left_d = len_full;
				end
			end
			PH_DATA: begin
				sum_d = sum_q + byte_s1;
				if (left_q == len_q) begin
					first_d = byte_s1;
				end
				left_d = left_q - 16'd1;
				if (pass) begin
					res_valid = 1'b1;
					res.out_kind = KIND_PAYLOAD;
					res.payload_byte = byte_s1;
				end
			end
			PH_CHECK: begin
				sum_bad_d = (sum_q != byte_s1);
			end
			PH_CLOSE: begin
				res_valid = 1'b1;
				res.out_kind = KIND_STATUS;
				res.is_last = 1'b1;
				res.frame_type = type_q;
				res.command_code = cmd_q;
				res.payload_len = len_q;
				res.status = close_st;
				res.module_error_code = (cmd_q == ERR_CMD) ? first_q : 8'h0;
			end
			default: begin
				type_d = 8'h0;
				cmd_d = 8'h0;
				len_d = 16'h0;
				left_d = 16'h0;
				sum_d = 8'h0;
				first_d = 8'h0;
				sum_bad_d = 1'b0;
			end
		endcase
		res_valid = res_valid && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			type_q <= 8'h0;
			cmd_q <= 8'h0;
			len_q <= 16'h0;
			left_q <= 16'h0;
			sum_q <= 8'h0;
			first_q <= 8'h0;
			sum_bad_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			type_q <= type_d;
			cmd_q <= cmd_d;
			len_q <= len_d;
			left_q <= left_d;
			sum_q <= sum_d;
			first_q <= first_d;
			sum_bad_q <= sum_bad_d;
		end
	end

	a_close_to_wait: assert property (@(posedge clk) disable iff (!arst_n)
		fire && phase_q == PH_CLOSE |=> phase_q == PH_WAIT)
		else $error("parser did not return to header wait after close");

	a_data_has_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> left_q != 16'h0)
		else $error("data phase with no payload bytes left");

	a_result_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> valid_s1 && room)
		else $error("result without a byte in the input register");

endmodule

>>> sv/rmfp_outbuf.sv
`timescale 1ns / 1ps
// Output register with one skid entry for the parser results.
// Depends on rmfp_pkg.
module rmfp_outbuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rmfp_pkg::res_t push_res,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output rmfp_pkg::res_t out_res
);
	import rmfp_pkg::*;

	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop = main_v_q && out_ready;
	assign room = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop && skid_v_q) begin
			skid_v_q <= 1'b0;
		end else if (pop) begin
			main_v_q <= push;
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_v_q) begin
			main_q <= skid_q;
		end else if (push && (pop || !main_v_q)) begin
			main_q <= push_res;
		end else if (push) begin
			skid_q <= push_res;
		end
	end

	assign out_valid = main_v_q;
	assign out_res = main_q;

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> main_v_q)
		else $error("skid entry held while output register empty");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_v_q)
		else $error("result pushed into full output buffer");

	a_skid_moves_up: assert property (@(posedge clk) disable iff (!arst_n)
		pop && skid_v_q |=> main_v_q && !skid_v_q)
		else $error("skid entry not moved into output register");

endmodule
